/* sv/scl_pkg.sv */
`default_nettype none

package scl_pkg;

    localparam int MAX_WORD    = 64;
    localparam int NUMBER_BITS = 16;
    localparam int LINE_LENGTH = 256;
    localparam int POS_LIMIT   = (LINE_LENGTH - 1 < 255) ? (LINE_LENGTH - 1) : 255;
    localparam int MAX_RESULTS = 3;
    localparam int NUM_KW      = 6;

    localparam logic [2:0] PK_NONE   = 3'd0;
    localparam logic [2:0] PK_LT     = 3'd1;
    localparam logic [2:0] PK_GT     = 3'd2;
    localparam logic [2:0] PK_ASSIGN = 3'd3;
    localparam logic [2:0] PK_BANG   = 3'd4;
    localparam logic [2:0] PK_NUM    = 3'd5;
    localparam logic [2:0] PK_WORD   = 3'd6;

    localparam logic [4:0] TK_EOF    = 5'd0;
    localparam logic [4:0] TK_SEMI   = 5'd1;
    localparam logic [4:0] TK_DOLLAR = 5'd2;
    localparam logic [4:0] TK_HASH   = 5'd3;
    localparam logic [4:0] TK_LPAREN = 5'd4;
    localparam logic [4:0] TK_RPAREN = 5'd5;
    localparam logic [4:0] TK_QUOTE  = 5'd6;
    localparam logic [4:0] TK_LT     = 5'd7;
    localparam logic [4:0] TK_LE     = 5'd8;
    localparam logic [4:0] TK_GT     = 5'd9;
    localparam logic [4:0] TK_GE     = 5'd10;
    localparam logic [4:0] TK_ASSIGN = 5'd11;
    localparam logic [4:0] TK_EQ     = 5'd12;
    localparam logic [4:0] TK_NE     = 5'd13;
    localparam logic [4:0] TK_PLUS   = 5'd14;
    localparam logic [4:0] TK_MINUS  = 5'd15;
    localparam logic [4:0] TK_STAR   = 5'd16;
    localparam logic [4:0] TK_SLASH  = 5'd17;
    localparam logic [4:0] TK_PCT    = 5'd18;
    localparam logic [4:0] TK_NUMBER = 5'd19;
    localparam logic [4:0] TK_KW0    = 5'd20;
    localparam logic [4:0] TK_IDENT  = 5'd26;
    localparam logic [4:0] TK_ERROR  = 5'd27;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd4, 3'd3, 3'd2, 3'd3, 3'd5};
    localparam logic [7:0] KW_TEXT [NUM_KW][5] = '{
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},
        '{8'h65, 8'h6C, 8'h69, 8'h66, 8'h00},
        '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h74, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65}
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  start;
        logic [6:0]  wlen;
        logic [15:0] value;
        logic        warn;
    } t_tok;

    typedef struct packed {
        t_tok [MAX_RESULTS-1:0] toks;
        logic [1:0]             count;
    } t_step_res;

endpackage

`default_nettype wire

/* sv/scl_lex.sv */
`default_nettype none

module scl_lex (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_eol,
    output scl_pkg::t_step_res    o_res
);

    localparam int NB = scl_pkg::NUMBER_BITS;

    logic [2:0]    r_pk, n_pk;
    logic [NB-1:0] r_acc, n_acc;
    logic [7:0]    r_pos, n_pos;
    logic [7:0]    r_ts, n_ts;
    logic [6:0]    r_wc, n_wc;
    logic [5:0]    r_mask, n_mask;

    scl_pkg::t_tok [scl_pkg::MAX_RESULTS-1:0] v_tok;
    logic [1:0] v_n;
    logic       v_used;
    logic [4:0] v_single;
    logic [2:0] v_pend;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic [7:0] kw_byte(input int k, input logic [6:0] idx);
        logic [7:0] b;
        b = 8'd0;
        if (idx < 7'd5) begin
            b = scl_pkg::KW_TEXT[k][idx[2:0]];
        end
        return b;
    endfunction

    function automatic logic [5:0] word_mask(input logic [5:0] m, input logic [6:0] wc,
                                             input logic [7:0] c);
        logic [5:0] r;
        r = m;
        for (int k = 0; k < scl_pkg::NUM_KW; k++) begin
            if (wc >= 7'(scl_pkg::KW_LEN[k]) || kw_byte(k, wc) != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] word_kind(input logic [5:0] m, input logic [6:0] wc);
        logic [4:0] kd;
        kd = scl_pkg::TK_IDENT;
        for (int k = scl_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (m[k] && 7'(scl_pkg::KW_LEN[k]) == wc) begin
                kd = scl_pkg::TK_KW0 + 5'(k);
            end
        end
        return kd;
    endfunction

    function automatic scl_pkg::t_tok mk_tok(input logic [4:0] kd, input logic [7:0] st,
                                             input logic [6:0] wl, input logic [NB-1:0] val,
                                             input logic wn);
        scl_pkg::t_tok t;
        t.kind  = kd;
        t.start = st;
        t.wlen  = wl;
        t.value = 16'(val);
        t.warn  = wn;
        return t;
    endfunction

    function automatic scl_pkg::t_tok flush_tok(input logic [2:0] pk, input logic [7:0] ts,
                                                input logic [NB-1:0] acc, input logic [6:0] wc,
                                                input logic [5:0] m, input logic wn);
        scl_pkg::t_tok t;
        t = mk_tok(scl_pkg::TK_ERROR, ts, 7'd0, '0, 1'b0);
        unique case (pk)
            scl_pkg::PK_LT:     t.kind = scl_pkg::TK_LT;
            scl_pkg::PK_GT:     t.kind = scl_pkg::TK_GT;
            scl_pkg::PK_ASSIGN: t.kind = scl_pkg::TK_ASSIGN;
            scl_pkg::PK_NUM:    t = mk_tok(scl_pkg::TK_NUMBER, ts, 7'd0, acc, wn);
            scl_pkg::PK_WORD:   t = mk_tok(word_kind(m, wc), ts, wc, '0, 1'b0);
            default:            t.kind = scl_pkg::TK_ERROR;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] combo_kind(input logic [2:0] pk);
        logic [4:0] kd;
        unique case (pk)
            scl_pkg::PK_LT:     kd = scl_pkg::TK_LE;
            scl_pkg::PK_GT:     kd = scl_pkg::TK_GE;
            scl_pkg::PK_ASSIGN: kd = scl_pkg::TK_EQ;
            default:            kd = scl_pkg::TK_NE;
        endcase
        return kd;
    endfunction

    always_comb begin
        unique case (i_ch)
            scl_pkg::CH_SEMI:   v_single = scl_pkg::TK_SEMI;
            scl_pkg::CH_DOLLAR: v_single = scl_pkg::TK_DOLLAR;
            scl_pkg::CH_HASH:   v_single = scl_pkg::TK_HASH;
            scl_pkg::CH_LPAREN: v_single = scl_pkg::TK_LPAREN;
            scl_pkg::CH_RPAREN: v_single = scl_pkg::TK_RPAREN;
            scl_pkg::CH_QUOTE:  v_single = scl_pkg::TK_QUOTE;
            scl_pkg::CH_PLUS:   v_single = scl_pkg::TK_PLUS;
            scl_pkg::CH_MINUS:  v_single = scl_pkg::TK_MINUS;
            scl_pkg::CH_STAR:   v_single = scl_pkg::TK_STAR;
            scl_pkg::CH_SLASH:  v_single = scl_pkg::TK_SLASH;
            scl_pkg::CH_PCT:    v_single = scl_pkg::TK_PCT;
            default:            v_single = scl_pkg::TK_EOF;
        endcase
        unique case (i_ch)
            scl_pkg::CH_LT:   v_pend = scl_pkg::PK_LT;
            scl_pkg::CH_GT:   v_pend = scl_pkg::PK_GT;
            scl_pkg::CH_EQ:   v_pend = scl_pkg::PK_ASSIGN;
            scl_pkg::CH_BANG: v_pend = scl_pkg::PK_BANG;
            default:          v_pend = scl_pkg::PK_NONE;
        endcase
    end

    always_comb begin
        n_pk   = r_pk;
        n_acc  = r_acc;
        n_pos  = r_pos;
        n_ts   = r_ts;
        n_wc   = r_wc;
        n_mask = r_mask;
        v_tok  = '0;
        v_n    = 2'd0;
        v_used = 1'b0;

        unique case (r_pk)
            scl_pkg::PK_LT, scl_pkg::PK_GT, scl_pkg::PK_ASSIGN, scl_pkg::PK_BANG: begin
                if (i_ch == scl_pkg::CH_EQ) begin
                    v_tok[v_n] = mk_tok(combo_kind(r_pk), r_ts, 7'd0, '0, 1'b0);
                    v_n = v_n + 2'd1;
                    n_pk = scl_pkg::PK_NONE;
                    v_used = 1'b1;
                end
            end
            scl_pkg::PK_NUM: begin
                if (is_digit(i_ch)) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + NB'(i_ch - scl_pkg::CH_ZERO);
                    v_used = 1'b1;
                end
            end
            scl_pkg::PK_WORD: begin
                if (is_alnum(i_ch)) begin
                    n_mask = word_mask(r_mask, r_wc, i_ch);
                    n_wc = r_wc + 7'd1;
                    v_used = 1'b1;
                    if (n_wc >= 7'(scl_pkg::MAX_WORD)) begin
                        v_tok[v_n] = mk_tok(word_kind(n_mask, n_wc), r_ts, n_wc, '0, 1'b0);
                        v_n = v_n + 2'd1;
                        n_pk = scl_pkg::PK_NONE;
                        n_wc = 7'd0;
                        n_mask = 6'h3F;
                    end
                end
            end
            default: n_pk = scl_pkg::PK_NONE;
        endcase

        if (!v_used) begin
            if (n_pk != scl_pkg::PK_NONE) begin
                v_tok[v_n] = flush_tok(n_pk, n_ts, n_acc, n_wc, n_mask,
                                       i_ch == scl_pkg::CH_DOT);
                v_n = v_n + 2'd1;
                n_acc = '0;
                n_wc = 7'd0;
                n_mask = 6'h3F;
                n_pk = scl_pkg::PK_NONE;
            end
            if (!is_space(i_ch)) begin
                if (v_single != scl_pkg::TK_EOF) begin
                    v_tok[v_n] = mk_tok(v_single, r_pos, 7'd0, '0, 1'b0);
                    v_n = v_n + 2'd1;
                end else if (v_pend != scl_pkg::PK_NONE) begin
                    n_pk = v_pend;
                    n_ts = r_pos;
                end else if (is_digit(i_ch)) begin
                    n_pk = scl_pkg::PK_NUM;
                    n_ts = r_pos;
                    n_acc = NB'(i_ch - scl_pkg::CH_ZERO);
                end else begin
                    n_pk = scl_pkg::PK_WORD;
                    n_ts = r_pos;
                    n_mask = word_mask(6'h3F, 7'd0, i_ch);
                    n_wc = 7'd1;
                    if (n_wc >= 7'(scl_pkg::MAX_WORD)) begin
                        v_tok[v_n] = mk_tok(word_kind(n_mask, n_wc), r_pos, n_wc, '0, 1'b0);
                        v_n = v_n + 2'd1;
                        n_pk = scl_pkg::PK_NONE;
                        n_wc = 7'd0;
                        n_mask = 6'h3F;
                    end
                end
            end
        end

        if (r_pos < 8'(scl_pkg::POS_LIMIT)) begin
            n_pos = r_pos + 8'd1;
        end

        if (i_eol) begin
            if (n_pk != scl_pkg::PK_NONE) begin
                v_tok[v_n] = flush_tok(n_pk, n_ts, n_acc, n_wc, n_mask, 1'b0);
                v_n = v_n + 2'd1;
            end
            v_tok[v_n] = mk_tok(scl_pkg::TK_EOF, n_pos, 7'd0, '0, 1'b0);
            v_n = v_n + 2'd1;
            n_pk   = scl_pkg::PK_NONE;
            n_acc  = '0;
            n_pos  = 8'd0;
            n_ts   = 8'd0;
            n_wc   = 7'd0;
            n_mask = 6'h3F;
        end
    end

    assign o_res = {v_tok, v_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk   <= scl_pkg::PK_NONE;
            r_acc  <= '0;
            r_pos  <= 8'd0;
            r_ts   <= 8'd0;
            r_wc   <= 7'd0;
            r_mask <= 6'h3F;
        end else if (i_en) begin
            r_pk   <= n_pk;
            r_acc  <= n_acc;
            r_pos  <= n_pos;
            r_ts   <= n_ts;
            r_wc   <= n_wc;
            r_mask <= n_mask;
        end
    end

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_eol |=> r_pos == 8'd0 && r_pk == scl_pkg::PK_NONE)
        else $error("Line end did not return the lexer to its start state.");

    a_eol_last_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_eol |-> v_n != 2'd0 && v_tok[v_n - 2'd1].kind == scl_pkg::TK_EOF)
        else $error("Line end did not finish with an end-of-file token.");

    a_word_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc < 7'(scl_pkg::MAX_WORD))
        else $error("Pending word length reached the word limit.");

endmodule

`default_nettype wire

/* sv/scl_outq.sv */
`default_nettype none

module scl_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire scl_pkg::t_step_res  i_res,
    output logic                     o_can_load,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output scl_pkg::t_tok            o_tok,
    output logic                     o_last
);

    scl_pkg::t_tok r_buf [scl_pkg::MAX_RESULTS];
    logic [1:0]    r_cnt;
    logic [1:0]    r_head;
    logic          pop;

    assign o_valid    = r_cnt != 2'd0;
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_tok      = r_buf[r_head];
    assign o_last     = r_cnt == 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (i_load) begin
            r_cnt  <= i_res.count;
            r_head <= 2'd0;
        end else if (pop) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < scl_pkg::MAX_RESULTS; k++) begin
                r_buf[k] <= i_res.toks[k];
            end
        end
    end

    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} + {1'b0, r_cnt} <= 3'(scl_pkg::MAX_RESULTS))
        else $error("Result queue read past its last entry.");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_res.count != 2'd0 |=> o_valid && r_head == 2'd0)
        else $error("Loaded results were not presented.");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && o_last && !i_load |=> !o_valid)
        else $error("Queue still held results after the last one left.");

endmodule

`default_nettype wire

/* sv/shell_command_lexer_core.sv */
`default_nettype none

// Streaming command-line lexer: one character per input transaction, up to three tokens
// per character on the output, one token per output transaction; the token that ends the
// results of a character carries last_of_run, and a character marked end_of_line always
// ends with an end-of-file token and restarts the line. A character is lexed from the input
// register once the result queue can take its tokens, so the input takes one character per
// cycle while the consumer keeps up and each character yields at most one token; a character
// with several tokens holds the input until the single output port of the result queue is
// passing its last token on.
module shell_command_lexer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_end_of_line,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_token_kind,
    output logic [7:0]       o_start_position,
    output logic [6:0]       o_word_length,
    output logic [15:0]      o_number_value,
    output logic             o_number_warning,
    output logic             o_last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_eol;
    logic       can_load;
    logic       adv;

    scl_pkg::t_step_res step_res;
    scl_pkg::t_tok      head_tok;

    assign adv        = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch  <= i_ch;
            r_eol <= i_end_of_line;
        end
    end

    scl_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ch    (r_ch),
        .i_eol   (r_eol),
        .o_res   (step_res)
    );

    scl_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_res      (step_res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_tok      (head_tok),
        .o_last     (o_last_of_run)
    );

    assign o_token_kind     = head_tok.kind;
    assign o_start_position = head_tok.start;
    assign o_word_length    = head_tok.wlen;
    assign o_number_value   = head_tok.value;
    assign o_number_warning = head_tok.warn;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !can_load |=> r_in_valid && $stable(r_ch) && $stable(r_eol))
        else $error("A registered character was lost while the queue was busy.");

endmodule

`default_nettype wire
